// ===== rtl/core/mll_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Micro-language lexer package
// Token codes, the token record, the scanner result record and the reserved
// word tables shared by the lexer modules.
// ----------------------------------------------------------------------------
package mll_pkg;

   localparam logic [3:0] TK_BEGIN  = 4'd0;
   localparam logic [3:0] TK_END    = 4'd1;
   localparam logic [3:0] TK_READ   = 4'd2;
   localparam logic [3:0] TK_WRITE  = 4'd3;
   localparam logic [3:0] TK_ID     = 4'd4;
   localparam logic [3:0] TK_CONST  = 4'd5;
   localparam logic [3:0] TK_LPAREN = 4'd6;
   localparam logic [3:0] TK_RPAREN = 4'd7;
   localparam logic [3:0] TK_SEMI   = 4'd8;
   localparam logic [3:0] TK_COMMA  = 4'd9;
   localparam logic [3:0] TK_ASSIGN = 4'd10;
   localparam logic [3:0] TK_PLUS   = 4'd11;
   localparam logic [3:0] TK_MINUS  = 4'd12;
   localparam logic [3:0] TK_EOT    = 4'd13;
   localparam logic [3:0] TK_ERROR  = 4'd14;

   localparam int unsigned LEN_W   = 6;
   localparam int unsigned VALUE_W = 31;

   typedef struct packed {
      logic [3:0]         kind;
      logic [LEN_W-1:0]   length;
      logic [VALUE_W-1:0] value;
      logic               last;
   } token_type;

   // Up to two tokens produced by one character.
   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } scan_out_type;

   // Reserved words: inicio, fin, leer, escribir (index equals token code).
   localparam logic [7:0] KW_TEXT [4][8] = '{
      '{8'h69, 8'h6E, 8'h69, 8'h63, 8'h69, 8'h6F, 8'h00, 8'h00},
      '{8'h66, 8'h69, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h6C, 8'h65, 8'h65, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h65, 8'h73, 8'h63, 8'h72, 8'h69, 8'h62, 8'h69, 8'h72}
   };
   localparam logic [LEN_W-1:0] KW_LEN [4] = '{6'd6, 6'd3, 6'd4, 6'd8};

   // True when reserved word k has character c at position pos.
   function automatic logic kw_match(input logic [1:0] k, input logic [LEN_W-1:0] pos,
                                     input logic [7:0] c);
      logic hit;
      hit = 1'b0;
      if (pos < KW_LEN[k]) begin
         hit = (KW_TEXT[k][pos[2:0]] == c);
      end
      return hit;
   endfunction

endpackage

// ===== rtl/core/mll_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexer scanner
// Holds the automaton state and turns one character into up to two tokens.
// ----------------------------------------------------------------------------
module mll_scanner #(
   parameter int unsigned MAX_LEXEME = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            char_code,
   input  logic                  end_of_input,
   output mll_pkg::scan_out_type scan_out
);
   import mll_pkg::*;

   localparam logic [LEN_W-1:0]   MaxLen   = LEN_W'(MAX_LEXEME);
   localparam logic [VALUE_W-1:0] ValueMax = '1;

   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_IDENT = 4'b0010,
      ST_CONST = 4'b0100,
      ST_COLON = 4'b1000
   } st_type;

   st_type             st_ff, st_in;
   logic [LEN_W-1:0]   cnt_ff, cnt_in;
   logic [3:0]         cand_ff, cand_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;

   logic               is_letter, is_digit, is_space;
   logic [3:0]         digit;
   logic [3:0]         cand_take, cand_start;
   logic [LEN_W-1:0]   cnt_sat;
   logic [VALUE_W+3:0] acc_x10;
   logic [VALUE_W-1:0] acc_sat;
   token_type          id_tok, const_tok;

   // Idle-state scan of the current character.
   logic               idle_valid;
   token_type          idle_tok;
   st_type             idle_st;
   logic [LEN_W-1:0]   idle_cnt;
   logic [3:0]         idle_cand;
   logic [VALUE_W-1:0] idle_acc;

   token_type          t0, t1;
   logic [1:0]         n;

   assign is_letter = ((char_code >= 8'h41) && (char_code <= 8'h5A)) ||
                      ((char_code >= 8'h61) && (char_code <= 8'h7A));
   assign is_digit  = (char_code >= 8'h30) && (char_code <= 8'h39);
   assign is_space  = (char_code == 8'h20) || ((char_code >= 8'h09) && (char_code <= 8'h0D));
   assign digit     = char_code[3:0];
   assign cnt_sat   = (cnt_ff < MaxLen) ? cnt_ff + 1'b1 : cnt_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         cand_take[k]  = cand_ff[k] & kw_match(2'(k), cnt_ff, char_code);
         cand_start[k] = kw_match(2'(k), '0, char_code);
      end
   end

   // Value times ten plus the digit, saturating.
   assign acc_x10 = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + (VALUE_W+4)'(digit);
   assign acc_sat = (acc_x10 > (VALUE_W+4)'(ValueMax)) ? ValueMax : acc_x10[VALUE_W-1:0];

   always_comb begin
      id_tok        = '0;
      id_tok.kind   = TK_ID;
      id_tok.length = cnt_ff;
      for (int k = 0; k < 4; k++) begin
         if (cand_ff[k] && (cnt_ff == KW_LEN[k])) begin
            id_tok.kind = 4'(k);
         end
      end
      const_tok        = '0;
      const_tok.kind   = TK_CONST;
      const_tok.length = cnt_ff;
      const_tok.value  = acc_ff;
   end

   always_comb begin
      idle_valid = 1'b0;
      idle_tok   = '0;
      idle_st    = ST_IDLE;
      idle_cnt   = cnt_ff;
      idle_cand  = cand_ff;
      idle_acc   = acc_ff;
      if (is_letter) begin
         idle_st   = ST_IDENT;
         idle_cnt  = LEN_W'(1);
         idle_cand = cand_start;
      end else if (is_digit) begin
         idle_st  = ST_CONST;
         idle_cnt = LEN_W'(1);
         idle_acc = VALUE_W'(digit);
      end else if (char_code == CH_COLON) begin
         idle_st = ST_COLON;
      end else if (!is_space) begin
         idle_valid = 1'b1;
         case (char_code)
            CH_PLUS:   idle_tok.kind = TK_PLUS;
            CH_MINUS:  idle_tok.kind = TK_MINUS;
            CH_LPAREN: idle_tok.kind = TK_LPAREN;
            CH_RPAREN: idle_tok.kind = TK_RPAREN;
            CH_COMMA:  idle_tok.kind = TK_COMMA;
            CH_SEMI:   idle_tok.kind = TK_SEMI;
            default:   idle_tok.kind = TK_ERROR;
         endcase
      end
   end

   always_comb begin
      st_in   = st_ff;
      cnt_in  = cnt_ff;
      cand_in = cand_ff;
      acc_in  = acc_ff;
      t0      = '0;
      t1      = '0;
      n       = 2'd0;
      if (end_of_input) begin
         st_in   = ST_IDLE;
         t1.kind = TK_EOT;
         n       = 2'd2;
         case (st_ff)
            ST_IDENT: t0 = id_tok;
            ST_CONST: t0 = const_tok;
            ST_COLON: t0.kind = TK_ERROR;
            default: begin
               t0.kind = TK_EOT;
               n       = 2'd1;
            end
         endcase
      end else begin
         case (st_ff)
            ST_IDENT: begin
               if (is_letter || is_digit) begin
                  cand_in = cand_take;
                  cnt_in  = cnt_sat;
               end else begin
                  t0      = id_tok;
                  t1      = idle_tok;
                  n       = idle_valid ? 2'd2 : 2'd1;
                  st_in   = idle_st;
                  cnt_in  = idle_cnt;
                  cand_in = idle_cand;
                  acc_in  = idle_acc;
               end
            end
            ST_CONST: begin
               if (is_digit) begin
                  acc_in = acc_sat;
                  cnt_in = cnt_sat;
               end else begin
                  t0      = const_tok;
                  t1      = idle_tok;
                  n       = idle_valid ? 2'd2 : 2'd1;
                  st_in   = idle_st;
                  cnt_in  = idle_cnt;
                  cand_in = idle_cand;
                  acc_in  = idle_acc;
               end
            end
            ST_COLON: begin
               // The character after a colon is consumed either way.
               t0.kind = (char_code == CH_EQUAL) ? TK_ASSIGN : TK_ERROR;
               n       = 2'd1;
               st_in   = ST_IDLE;
            end
            default: begin
               t0      = idle_tok;
               n       = idle_valid ? 2'd1 : 2'd0;
               st_in   = idle_st;
               cnt_in  = idle_cnt;
               cand_in = idle_cand;
               acc_in  = idle_acc;
            end
         endcase
      end
      t0.last = (n == 2'd1);
      t1.last = (n == 2'd2);
   end

   assign scan_out.count  = n;
   assign scan_out.first  = t0;
   assign scan_out.second = t1;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         cnt_ff  <= '0;
         cand_ff <= 4'hF;
         acc_ff  <= '0;
      end else if (step) begin
         st_ff   <= st_in;
         cnt_ff  <= cnt_in;
         cand_ff <= cand_in;
         acc_ff  <= acc_in;
      end
   end

`ifndef SYNTH
   // End of input always closes with at least the end-of-text token.
   a_eoi_emits: assert property (@(posedge clock) disable iff (reset)
      step && end_of_input |-> scan_out.count != 2'd0)
      else $error("end of input produced no token");

   // Only the final token of a character carries the last flag.
   a_two_last: assert property (@(posedge clock) disable iff (reset)
      step && scan_out.count == 2'd2 |-> scan_out.second.last && !scan_out.first.last)
      else $error("last flag misplaced on a token pair");

   // The length never passes the limit.
   a_len_sat: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MaxLen)
      else $error("lexeme count beyond limit");
`endif

endmodule

// ===== rtl/core/mll_token_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexer token queue
// Four-entry queue taking up to two tokens per cycle and giving one.
// ----------------------------------------------------------------------------
module mll_token_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mll_pkg::scan_out_type push_data,
   input  logic                  pop,
   output mll_pkg::token_type    head,
   output logic                  not_empty,
   output logic                  room_two
);
   import mll_pkg::*;

   localparam int unsigned Depth = 4;
   localparam int unsigned PtrW  = $clog2(Depth);

   token_type         mem_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]     count_ff, count_in;
   logic [1:0]        push_n;
   logic [PtrW-1:0]   wr_next;

   assign push_n    = push ? push_data.count : 2'd0;
   assign wr_next   = wr_ptr_ff + 1'b1;
   assign not_empty = (count_ff != '0);
   assign room_two  = (count_ff <= (PtrW+1)'(Depth - 2));
   assign head      = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + PtrW'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PtrW'(pop);
   assign count_in  = count_ff + (PtrW+1)'(push_n) - (PtrW+1)'(pop);

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_data.first;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_next] <= push_data.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PtrW+1)'(Depth))
      else $error("token queue overflow");

   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      PtrW'(wr_ptr_ff - rd_ptr_ff) == count_ff[PtrW-1:0])
      else $error("token queue pointers disagree with fill count");
`endif

endmodule

// ===== rtl/core/micro_language_lexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Micro-language lexer
// Table-driven scanner for a small language, one ASCII character per
// transaction in, one token per transaction out.
// ----------------------------------------------------------------------------
// The lexer accepts one character (or an end-of-input mark) per clock cycle
// while the token queue has room, and returns tokens: the four reserved
// words, identifiers, decimal constants with their saturated value, the
// punctuation symbols, assignment, end of text and lexical errors. A
// character passes an input register and the scanner logic into a
// four-entry token queue; a token is on offer once it is written into the
// queue, and the input register holds its character while the queue lacks
// room. A character that ends an identifier or a constant and itself gives
// a token, and every end of input that flushes a pending identifier,
// constant or colon, yields two tokens; the output port moves one token per
// cycle while rsp_tready is high, so such characters need two output
// transfers and the input stalls whenever the queue cannot take two more
// tokens. The last token caused by a character is marked by rsp_tlast.
// Lexeme lengths saturate at MAX_LEXEME and constants at 2^31-1.
// ----------------------------------------------------------------------------
module micro_language_lexer #(
   parameter int unsigned MAX_LEXEME = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Character channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic [0:0]  req_tuser,   // [0] end_of_input
   // Token channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [3:0] token_kind, [9:4] lexeme_length,
                                    // [40:10] const_value, [47:41] zero
   output logic        rsp_tlast    // last_token
);
   import mll_pkg::*;

   logic         in_valid_ff;
   logic [7:0]   in_char_ff;
   logic         in_eoi_ff;
   logic         step;
   logic         req_fire;
   logic         rsp_fire;
   logic         fifo_room;
   scan_out_type scan_out;
   token_type    head;

   // The held character is scanned once the queue can take both of its
   // possible tokens; the input register refills in that same cycle.
   assign step       = in_valid_ff && fifo_room;
   assign req_tready = !in_valid_ff || step;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_char_ff <= req_tdata;
         in_eoi_ff  <= req_tuser[0];
      end
   end

   mll_scanner #(
      .MAX_LEXEME (MAX_LEXEME)
   ) u_scanner (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .char_code    (in_char_ff),
      .end_of_input (in_eoi_ff),
      .scan_out     (scan_out)
   );

   mll_token_fifo u_token_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .push_data (scan_out),
      .pop       (rsp_fire),
      .head      (head),
      .not_empty (rsp_tvalid),
      .room_two  (fifo_room)
   );

   assign rsp_tdata = {7'b0000000, head.value, head.length, head.kind};
   assign rsp_tlast = head.last;

endmodule
